### hw/rtl/lge_pkg.sv
`timescale 1ns / 1ps

package lge_pkg;

    localparam int GRID_WIDTH  = 64;
    localparam int GRID_HEIGHT = 64;
    localparam int ROW_AW      = $clog2(GRID_HEIGHT);
    localparam int COL_AW      = $clog2(GRID_WIDTH);
    localparam int POS_W       = 6;
    localparam int GEN_W       = 32;
    localparam int NB_W        = 4;

    localparam logic [NB_W-1:0] BIRTH_COUNT   = NB_W'(3);
    localparam logic [NB_W-1:0] SURVIVE_COUNT = NB_W'(2);

    typedef enum logic [1:0] {
        ACT_WRITE   = 2'd0,
        ACT_READ    = 2'd1,
        ACT_ADVANCE = 2'd2,
        ACT_CLEAR   = 2'd3
    } t_action;

    typedef logic [GRID_WIDTH-1:0] t_row;

    typedef struct packed {
        t_action          action;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             cell_in;
    } t_in_item;

    typedef struct packed {
        logic             cell_out;
        logic [GEN_W-1:0] generation_count;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic fetch;
        logic write_cell;
        logic clear;
        logic adv_init;
        logic adv_prime;
        logic adv_step;
        logic respond;
    } t_cmd;

    typedef struct packed {
        logic last_row;
    } t_sts;

    function automatic t_row life_row(input t_row up, input t_row mid, input t_row dn);
        t_row              res;
        logic [NB_W-1:0]   cnt;
        logic [GRID_WIDTH+1:0] u;
        logic [GRID_WIDTH+1:0] m;
        logic [GRID_WIDTH+1:0] d;
        u = {1'b0, up, 1'b0};
        m = {1'b0, mid, 1'b0};
        d = {1'b0, dn, 1'b0};
        for (int c = 0; c < GRID_WIDTH; c++) begin
            cnt = NB_W'(u[c]) + NB_W'(u[c+1]) + NB_W'(u[c+2])
                + NB_W'(m[c]) + NB_W'(m[c+2])
                + NB_W'(d[c]) + NB_W'(d[c+1]) + NB_W'(d[c+2]);
            res[c] = (cnt == BIRTH_COUNT) || (mid[c] && (cnt == SURVIVE_COUNT));
        end
        return res;
    endfunction

endpackage

### hw/rtl/life_grid_engine_core.sv
`timescale 1ns / 1ps

// channel   direction  handshake            payload
// command   in         start high, busy low i_item   (lge_pkg::t_in_item)
// result    out        o_strobe, one cycle  o_result (lge_pkg::t_out_item)
//
// busy after acceptance through the action and a finish state; advance takes longest,
// set by the row-by-row sweep through the one-read one-write row store
// the result beat comes in the first cycle with busy low; a new beat may start then
// synchronous active-low reset clears all rows through per-row valid bits at once
// the receiver cannot stall; every accepted beat yields exactly one result beat
module life_grid_engine_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  lge_pkg::t_in_item  i_item,
    output logic               busy,
    output logic               o_strobe,
    output lge_pkg::t_out_item o_result
);
    import lge_pkg::*;

    t_cmd cmd;
    t_sts sts;

    lge_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_action (i_item.action),
        .i_sts    (sts),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    lge_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

### hw/rtl/lge_ctrl.sv
`timescale 1ns / 1ps

module lge_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  lge_pkg::t_action i_action,
    input  lge_pkg::t_sts    i_sts,
    output lge_pkg::t_cmd    o_cmd,
    output logic             o_busy
);
    import lge_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FETCH_WR,
        S_FETCH_RD,
        S_WRITE,
        S_CLEAR,
        S_ADV0,
        S_ADV1,
        S_SWEEP,
        S_FIN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (i_action)
                        ACT_WRITE:   n_state = S_FETCH_WR;
                        ACT_READ:    n_state = S_FETCH_RD;
                        ACT_ADVANCE: n_state = S_ADV0;
                        default:     n_state = S_CLEAR;
                    endcase
                end
            end
            S_FETCH_WR: n_state = S_WRITE;
            S_FETCH_RD: n_state = S_FIN;
            S_WRITE:    n_state = S_FIN;
            S_CLEAR:    n_state = S_FIN;
            S_ADV0:     n_state = S_ADV1;
            S_ADV1:     n_state = S_SWEEP;
            S_SWEEP: begin
                if (i_sts.last_row) begin
                    n_state = S_FIN;
                end
            end
            S_FIN:      n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd            = '0;
        o_cmd.load       = (r_state == S_IDLE) && i_start;
        o_cmd.fetch      = (r_state == S_FETCH_WR) || (r_state == S_FETCH_RD);
        o_cmd.write_cell = (r_state == S_WRITE);
        o_cmd.clear      = (r_state == S_CLEAR);
        o_cmd.adv_init   = (r_state == S_ADV0);
        o_cmd.adv_prime  = (r_state == S_ADV1);
        o_cmd.adv_step   = (r_state == S_SWEEP);
        o_cmd.respond    = (r_state == S_FIN);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    assign o_busy = r_busy;

endmodule

### hw/rtl/lge_datapath.sv
`timescale 1ns / 1ps

module lge_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lge_pkg::t_in_item  i_item,
    input  lge_pkg::t_cmd      i_cmd,
    output lge_pkg::t_sts      o_sts,
    output logic               o_strobe,
    output lge_pkg::t_out_item o_result
);
    import lge_pkg::*;

    t_row                r_mem [GRID_HEIGHT];
    logic [GRID_HEIGHT-1:0] r_row_valid;
    t_row                r_rd_data;
    logic                r_rd_hit;

    t_in_item            r_item;
    t_row                r_up;
    t_row                r_mid;
    logic [ROW_AW-1:0]   r_idx;
    logic [GEN_W-1:0]    r_gen;
    logic                r_seeded;
    logic                r_strobe;
    t_out_item           r_result;

    logic                in_grid;
    logic [ROW_AW-1:0]   item_row;
    logic [COL_AW-1:0]   item_col;
    logic [ROW_AW:0]     ahead;
    logic                ahead_ok;
    t_row                eff_rd;
    logic                rd_en;
    logic [ROW_AW-1:0]   rd_addr;
    logic                wr_en;
    logic [ROW_AW-1:0]   wr_addr;
    t_row                wr_data;
    t_row                n_row;
    t_row                n_cell_row;
    logic [GEN_W-1:0]    n_gen;

    assign in_grid  = (int'(r_item.row) < GRID_HEIGHT) && (int'(r_item.col) < GRID_WIDTH);
    assign item_row = ROW_AW'(r_item.row);
    assign item_col = COL_AW'(r_item.col);
    assign ahead    = {1'b0, r_idx} + (ROW_AW+1)'(2);
    assign ahead_ok = ahead < (ROW_AW+1)'(GRID_HEIGHT);
    assign eff_rd   = r_rd_hit ? r_rd_data : '0;
    assign n_row    = life_row(r_up, r_mid, eff_rd);
    assign n_gen    = (r_seeded && (r_gen != '1)) ? r_gen + GEN_W'(1) : r_gen;

    always_comb begin
        n_cell_row           = eff_rd;
        n_cell_row[item_col] = r_item.cell_in;
    end

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = item_row;
        if (i_cmd.fetch) begin
            rd_en = 1'b1;
        end else if (i_cmd.adv_init) begin
            rd_en   = 1'b1;
            rd_addr = '0;
        end else if (i_cmd.adv_prime) begin
            rd_en   = 1'b1;
            rd_addr = ROW_AW'(1);
        end else if (i_cmd.adv_step) begin
            rd_en   = ahead_ok;
            rd_addr = ahead[ROW_AW-1:0];
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = item_row;
        wr_data = n_cell_row;
        if (i_cmd.write_cell) begin
            wr_en = in_grid;
        end else if (i_cmd.adv_step) begin
            wr_en   = 1'b1;
            wr_addr = r_idx;
            wr_data = n_row;
        end
    end

    // row store
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
            r_rd_hit    <= 1'b0;
            r_gen       <= '0;
            r_seeded    <= 1'b0;
            r_strobe    <= 1'b0;
        end else begin
            r_rd_hit <= rd_en && r_row_valid[rd_addr];
            r_strobe <= i_cmd.respond;
            if (i_cmd.clear) begin
                r_row_valid <= '0;
                r_gen       <= '0;
                r_seeded    <= 1'b0;
            end else begin
                if (wr_en) begin
                    r_row_valid[wr_addr] <= 1'b1;
                end
                if (i_cmd.write_cell && in_grid) begin
                    r_seeded <= 1'b1;
                end
                if (i_cmd.adv_step && o_sts.last_row) begin
                    r_gen <= n_gen;
                end
            end
        end
    end

    // item latch, sweep window and result beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
        if (i_cmd.adv_init) begin
            r_up  <= '0;
            r_idx <= '0;
        end
        if (i_cmd.adv_prime) begin
            r_mid <= eff_rd;
        end
        if (i_cmd.adv_step) begin
            r_up  <= r_mid;
            r_mid <= eff_rd;
            r_idx <= r_idx + ROW_AW'(1);
        end
        if (i_cmd.respond) begin
            r_result.cell_out         <= (r_item.action == ACT_READ) && in_grid
                                         && eff_rd[item_col];
            r_result.generation_count <= r_gen;
        end
    end

    assign o_sts.last_row = (r_idx == ROW_AW'(GRID_HEIGHT - 1));
    assign o_strobe       = r_strobe;
    assign o_result       = r_result;

`ifndef SYNTHESIS
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(i_cmd))
        else $error("datapath commands overlap");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |=> !r_strobe)
        else $error("result strobe held for two cycles");

    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear |=> (r_gen == '0) && !r_seeded)
        else $error("clear left counter or seed flag set");

    a_gen_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.clear |=> r_gen >= $past(r_gen))
        else $error("generation counter went backwards");

    a_seed_on_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.write_cell && in_grid) |=> r_seeded)
        else $error("write did not set seed flag");
`endif

endmodule

### tb/tb_life_grid_engine_core.sv
`timescale 1ns / 1ps

module tb_life_grid_engine_core;
    import lge_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 7;
    localparam int MAX_GAP      = 18;
    localparam int RANDOM_ITEMS = 116;
    localparam int DRAIN_CYCLES = 2 * GRID_HEIGHT + 16;
    localparam int WIN          = 8;
    localparam int REPORT_LIMIT = 10;

    typedef struct {
        t_in_item  item;
        bit        typed;
        t_out_item result;
    } t_script_row;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    t_in_item  i_item;
    logic      busy;
    logic      o_strobe;
    t_out_item o_result;

    bit [GRID_WIDTH-1:0] shadow_grid [GRID_HEIGHT];
    logic [GEN_W-1:0]    shadow_gen;
    bit                  shadow_seeded;

    t_out_item   results_due [$];
    t_script_row script [$];
    int          mismatch_count;
    int          beats_checked;
    int          action_count [4];

    life_grid_engine_core uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    initial begin
        #(2 * CLK_HALF * 200000);
        $display("Some tests failed");
        $finish;
    end

    function automatic int live_neighbours(int r, int c);
        int n;
        n = 0;
        for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
                if ((dr != 0 || dc != 0) && r + dr >= 0 && r + dr < GRID_HEIGHT
                    && c + dc >= 0 && c + dc < GRID_WIDTH) begin
                    n += shadow_grid[r + dr][c + dc];
                end
            end
        end
        return n;
    endfunction

    function automatic t_out_item life_predict(t_in_item it);
        t_out_item           res;
        bit [GRID_WIDTH-1:0] fresh [GRID_HEIGHT];
        bit                  on_grid;
        int                  n;
        res     = '0;
        on_grid = (int'(it.row) < GRID_HEIGHT) && (int'(it.col) < GRID_WIDTH);
        case (it.action)
            ACT_WRITE: begin
                if (on_grid) begin
                    shadow_grid[it.row][it.col] = it.cell_in;
                    shadow_seeded = 1'b1;
                end
            end
            ACT_READ: begin
                if (on_grid) res.cell_out = shadow_grid[it.row][it.col];
            end
            ACT_ADVANCE: begin
                for (int r = 0; r < GRID_HEIGHT; r++) begin
                    for (int c = 0; c < GRID_WIDTH; c++) begin
                        n = live_neighbours(r, c);
                        if (shadow_grid[r][c])
                            fresh[r][c] = (n == int'(SURVIVE_COUNT)) || (n == int'(BIRTH_COUNT));
                        else
                            fresh[r][c] = (n == int'(BIRTH_COUNT));
                    end
                end
                shadow_grid = fresh;
                // counter holds at all ones
                if (shadow_seeded && shadow_gen != '1) shadow_gen = shadow_gen + 1'b1;
            end
            default: begin
                foreach (shadow_grid[r]) shadow_grid[r] = '0;
                shadow_gen    = '0;
                shadow_seeded = 1'b0;
            end
        endcase
        res.generation_count = shadow_gen;
        return res;
    endfunction

    function automatic void plan(t_action act, int r, int c, bit v, bit typed = 1'b0,
                                 bit alive = 1'b0, int unsigned gen = 0);
        t_script_row s;
        s.item.action                = act;
        s.item.row                   = POS_W'(r);
        s.item.col                   = POS_W'(c);
        s.item.cell_in               = v;
        s.typed                      = typed;
        s.result.cell_out            = alive;
        s.result.generation_count    = GEN_W'(gen);
        script.push_back(s);
    endfunction

    function automatic int pick_origin();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return GRID_HEIGHT - WIN;
            default: return $urandom_range(0, GRID_HEIGHT - WIN);
        endcase
    endfunction

    function automatic t_in_item random_item(int r0, int c0);
        t_in_item it;
        int       pick;
        pick       = $urandom_range(0, 99);
        it.row     = POS_W'(r0 + $urandom_range(0, WIN - 1));
        it.col     = POS_W'(c0 + $urandom_range(0, WIN - 1));
        it.cell_in = ($urandom_range(0, 3) != 0);
        if (pick < 3)       it.action = ACT_CLEAR;
        else if (pick < 45) it.action = ACT_WRITE;
        else if (pick < 78) it.action = ACT_READ;
        else                it.action = ACT_ADVANCE;
        // stray beat anywhere on the grid
        if ($urandom_range(0, 9) == 0) begin
            it.row     = POS_W'($urandom_range(0, 63));
            it.col     = POS_W'($urandom_range(0, 63));
            it.cell_in = 1'($urandom_range(0, 1));
        end
        return it;
    endfunction

    task automatic send_beat(input t_in_item it, input bit typed, input t_out_item typed_res,
                             input int gap);
        t_out_item due;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        due = life_predict(it);
        results_due.push_back(typed ? typed_res : due);
        action_count[it.action]++;
        @(negedge i_clk);
    endtask

    task automatic note_mismatch(input string field, input logic [GEN_W-1:0] want,
                                 input logic [GEN_W-1:0] got);
        if (mismatch_count < REPORT_LIMIT)
            $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, field, want, got);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_strobe) begin
            if (results_due.size() == 0) begin
                note_mismatch("unexpected beat", '0, o_result.generation_count);
            end else begin
                want = results_due.pop_front();
                beats_checked++;
                if (want.cell_out !== o_result.cell_out)
                    note_mismatch("cell_out", GEN_W'(want.cell_out),
                                  GEN_W'(o_result.cell_out));
                if (want.generation_count !== o_result.generation_count)
                    note_mismatch("generation_count", want.generation_count,
                                  o_result.generation_count);
            end
        end
    end

    initial begin
        t_in_item  it;
        t_out_item none;
        int        r0;
        int        c0;
        int        gap;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_item         = '0;
        none           = '0;
        mismatch_count = 0;
        beats_checked  = 0;
        foreach (action_count[a]) action_count[a] = 0;
        foreach (shadow_grid[r]) shadow_grid[r] = '0;
        shadow_gen     = '0;
        shadow_seeded  = 1'b0;

        //   action       row col v  typed alive gen
        plan(ACT_READ,     0,  0, 0, 1,    0,   0);
        plan(ACT_ADVANCE,  0,  0, 0, 1,    0,   0);  // unseeded, counter stays
        plan(ACT_WRITE,    0,  0, 0, 1,    0,   0);  // dead write still seeds
        plan(ACT_ADVANCE,  0,  0, 0, 1,    0,   1);
        plan(ACT_WRITE,   63, 63, 1);
        plan(ACT_WRITE,   63, 62, 1);
        plan(ACT_WRITE,   62, 63, 1);
        plan(ACT_WRITE,    0, 10, 1);
        plan(ACT_WRITE,    0, 11, 1);
        plan(ACT_WRITE,    0, 12, 1);
        plan(ACT_WRITE,   63,  0, 1);
        plan(ACT_WRITE,    0, 63, 1);
        plan(ACT_ADVANCE,  0,  0, 0);
        plan(ACT_READ,    62, 62, 0);                // birth in the corner
        plan(ACT_READ,     1, 11, 0);
        plan(ACT_READ,     0, 10, 0);
        plan(ACT_READ,    63,  0, 0);
        plan(ACT_ADVANCE,  0,  0, 0);
        plan(ACT_READ,     0, 11, 0);
        plan(ACT_CLEAR,    0,  0, 0, 1,    0,   0);
        plan(ACT_READ,    63, 63, 0, 1,    0,   0);
        plan(ACT_ADVANCE,  0,  0, 0, 1,    0,   0);
        plan(ACT_WRITE,   21, 42, 1, 1,    0,   0);
        plan(ACT_READ,    21, 42, 0, 1,    1,   0);

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (script[k])
            send_beat(script[k].item, script[k].typed, script[k].result,
                      $urandom_range(0, MAX_GAP));

        r0 = pick_origin();
        c0 = pick_origin();
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            // hold off until the engine has drained
            if (k == RANDOM_ITEMS / 2) begin
                start <= 1'b0;
                while (results_due.size() != 0) @(negedge i_clk);
            end
            gap = (k >= 40 && k < 70) ? 0 : $urandom_range(0, MAX_GAP);
            it  = random_item(r0, c0);
            send_beat(it, 1'b0, none, gap);
            if (it.action == ACT_CLEAR || $urandom_range(0, 29) == 0) begin
                r0 = pick_origin();
                c0 = pick_origin();
            end
        end
        start <= 1'b0;

        while (results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("checked %0d result beats: %0d writes, %0d reads, %0d generations, %0d clears",
                 beats_checked, action_count[ACT_WRITE], action_count[ACT_READ],
                 action_count[ACT_ADVANCE], action_count[ACT_CLEAR]);
        $display("final generation count %0d, %0d mismatches", shadow_gen, mismatch_count);
        if (mismatch_count == 0 && results_due.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### filelist.f
hw/rtl/lge_pkg.sv
hw/rtl/lge_ctrl.sv
hw/rtl/lge_datapath.sv
hw/rtl/life_grid_engine_core.sv
tb/tb_life_grid_engine_core.sv
